@@ hw/rtl/mpm2_pkg.sv @@
// ----------------------------------------------------------------------------
// mpm2_pkg
// Shared types, constants and helpers for the 2x2 modular matrix power block.
// ----------------------------------------------------------------------------
package mpm2_pkg;

  localparam int ENT_W = 30;
  localparam int EXP_W = 31;
  localparam int EXPONENT_BITS_DEF = 31;

  localparam logic [ENT_W-1:0] PRIME = 30'd998244353;
  localparam longint unsigned BARRETT_M_L = (64'd1 << 60) / 64'd998244353;
  localparam logic [30:0] BARRETT_M = BARRETT_M_L[30:0];

  typedef logic [ENT_W-1:0] ent_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_QUO,
    ST_QP,
    ST_SUB,
    ST_ACC,
    ST_DONE
  } state_t;

  function automatic ent_t reduce_entry(input ent_t v);
    reduce_entry = (v >= PRIME) ? ent_t'(v - PRIME) : v;
  endfunction

  function automatic logic [31:0] fix_once(input logic [31:0] v);
    fix_once = (v >= {2'b00, PRIME}) ? (v - {2'b00, PRIME}) : v;
  endfunction

endpackage

@@ hw/rtl/matrix_power_mod_prime_2x2_top.sv @@
// ----------------------------------------------------------------------------
// matrix_power_mod_prime_2x2_top
// Raises a 2x2 matrix of residues mod 998244353 to a power by square-and-multiply.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to hand in an item. All work runs on a single
// shared 31x31 multiplier: each modular product passes through the multiply,
// Barrett quotient, quotient times prime, subtract and final correct/add
// steps, a matrix product takes eight of them, and each of the EXPONENT_BITS
// exponent bits costs a squaring plus a multiply when the bit is set. A new
// item is not taken until the last one is through. The result appears for
// exactly one cycle with out_valid; the receiver cannot stall it, and busy
// stays high through that cycle.
module matrix_power_mod_prime_2x2_top
  import mpm2_pkg::*;
#(
  parameter int EXPONENT_BITS = EXPONENT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [ENT_W-1:0] in_entry_r0c0,
  input  logic [ENT_W-1:0] in_entry_r0c1,
  input  logic [ENT_W-1:0] in_entry_r1c0,
  input  logic [ENT_W-1:0] in_entry_r1c1,
  input  logic [EXP_W-1:0] in_exponent,
  output logic             out_valid,
  output logic [ENT_W-1:0] out_power_r0c0,
  output logic [ENT_W-1:0] out_power_r0c1,
  output logic [ENT_W-1:0] out_power_r1c0,
  output logic [ENT_W-1:0] out_power_r1c1
);

  localparam int CNT_W = $clog2(EXPONENT_BITS + 1);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(EXPONENT_BITS - 1);

  state_t           state_r, state_nxt;
  ent_t             acc_r  [4];
  ent_t             base_r [4];
  ent_t             res_r  [3];
  logic [EXP_W-1:0] exp_r;
  logic [CNT_W-1:0] cnt_r;
  logic             sq_r;
  logic [1:0]       ent_r;
  logic             term_r;
  logic [61:0]      mul_r;
  logic [31:0]      x_r;
  logic [31:0]      rem_r;
  ent_t             sum_r;

  logic [30:0]      mul_a, mul_b;
  ent_t             op_x, op_y;
  logic [31:0]      rem_fix;
  logic [31:0]      sum_raw;
  ent_t             prod_val, acc_val;
  logic             accept;

  assign accept = start && !busy;

  // operand select for the first multiply
  always_comb begin
    op_x = sq_r ? base_r[{ent_r[1], term_r}] : acc_r[{ent_r[1], term_r}];
    op_y = base_r[{term_r, ent_r[0]}];
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_MUL: begin
        mul_a = {1'b0, op_x};
        mul_b = {1'b0, op_y};
      end
      ST_QUO: begin
        mul_a = mul_r[59:29];
        mul_b = BARRETT_M;
      end
      ST_QP: begin
        mul_a = mul_r[61:31];
        mul_b = {1'b0, PRIME};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    rem_fix  = fix_once(rem_r);
    prod_val = rem_fix[ENT_W-1:0];
    sum_raw  = fix_once({2'b00, sum_r} + {2'b00, prod_val});
    acc_val  = term_r ? sum_raw[ENT_W-1:0] : prod_val;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_QUO;
      ST_QUO:  state_nxt = ST_QP;
      ST_QP:   state_nxt = ST_SUB;
      ST_SUB:  state_nxt = ST_ACC;
      ST_ACC: begin
        if (term_r && ent_r == 2'd3 && sq_r && cnt_r == LAST_BIT) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy      = (state_r != ST_IDLE);
    out_valid = (state_r == ST_DONE);
  end

  assign out_power_r0c0 = acc_r[0];
  assign out_power_r0c1 = acc_r[1];
  assign out_power_r1c0 = acc_r[2];
  assign out_power_r1c1 = acc_r[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          base_r[0] <= reduce_entry(in_entry_r0c0);
          base_r[1] <= reduce_entry(in_entry_r0c1);
          base_r[2] <= reduce_entry(in_entry_r1c0);
          base_r[3] <= reduce_entry(in_entry_r1c1);
          acc_r[0]  <= ent_t'(1);
          acc_r[1]  <= '0;
          acc_r[2]  <= '0;
          acc_r[3]  <= ent_t'(1);
          exp_r     <= in_exponent;
          cnt_r     <= '0;
          sq_r      <= !in_exponent[0];
          ent_r     <= '0;
          term_r    <= 1'b0;
        end
      end
      ST_QUO: x_r <= mul_r[31:0];
      // the quotient estimate can run up to two short, so correct twice
      ST_SUB: rem_r <= fix_once(x_r - mul_r[31:0]);
      ST_ACC: begin
        if (!term_r) begin
          sum_r  <= acc_val;
          term_r <= 1'b1;
        end else begin
          term_r <= 1'b0;
          if (ent_r != 2'd3) begin
            res_r[ent_r] <= acc_val;
            ent_r        <= ent_r + 2'd1;
          end else begin
            ent_r <= '0;
            if (sq_r) begin
              base_r[0] <= res_r[0];
              base_r[1] <= res_r[1];
              base_r[2] <= res_r[2];
              base_r[3] <= acc_val;
              // advance to the next exponent bit
              exp_r <= exp_r >> 1;
              cnt_r <= cnt_r + CNT_W'(1);
              sq_r  <= !exp_r[1];
            end else begin
              acc_r[0] <= res_r[0];
              acc_r[1] <= res_r[1];
              acc_r[2] <= res_r[2];
              acc_r[3] <= acc_val;
              sq_r     <= 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && !out_valid))
    else $error("accepted item did not raise busy");

  a_result_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_power_r0c0 < PRIME && out_power_r0c1 < PRIME &&
                   out_power_r1c0 < PRIME && out_power_r1c1 < PRIME))
    else $error("result entry not reduced");

  a_remainder_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACC) |-> (rem_fix < {2'b00, PRIME}))
    else $error("Barrett remainder out of range");
`endif

endmodule
